/* sv/sm3_pkg.sv */
`default_nettype none
package sm3_pkg;

    localparam logic [31:0] IV_A = 32'h7380166f;
    localparam logic [31:0] IV_B = 32'h4914b2b9;
    localparam logic [31:0] IV_C = 32'h172442d7;
    localparam logic [31:0] IV_D = 32'hda8a0600;
    localparam logic [31:0] IV_E = 32'ha96f30bc;
    localparam logic [31:0] IV_F = 32'h163138aa;
    localparam logic [31:0] IV_G = 32'he38dee4d;
    localparam logic [31:0] IV_H = 32'hb0fb0e4e;
    localparam logic [31:0] T_LOW = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Queue entry between front and back: one 32-bit block word or a final marker
    typedef enum logic [1:0] {
        OP_WORD = 2'd0,   // 16 of these fill a block
        OP_FINAL = 2'd1   // emit digest after previous blocks
    } op_t;

    typedef struct packed {
        op_t op;
        logic first;       // block begins a new message, reload IV
        logic [31:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_LOAD = 2'd0,
        BK_ROUND = 2'd1,
        BK_EMIT = 2'd2
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_IDLE = 2'd0,
        FR_PAD = 2'd1,
        FR_LEN = 2'd2,
        FR_FIN = 2'd3
    } fr_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

/* sv/sm3_hash_engine_top.sv */
`default_nettype none
// SM3 hash engine: gathers message bytes into 64-byte blocks and hashes them.
// Each block is loaded as 16 words and then run through 64 rounds in the
// single shared round unit; words are taken at one a cycle while the four-entry
// queue has room and no message is being padded. The digest is ready once the
// last block is hashed, padding needing one more block at times; then eight
// digest words are popped one a cycle. Reset clears all control state; the
// chaining value reloads the initial value at the start of each message.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    output logic full,
    input wire logic [31:0] message_word,
    input wire logic [2:0] byte_count,
    input wire logic last_word,
    output logic empty,
    input wire logic pop,
    output logic [31:0] digest_word,
    output logic [2:0] word_index,
    output logic digest_done
);

    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    sm3_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .message_word(message_word), .byte_count(byte_count), .last_word(last_word),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    sm3_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_data(f_cmd),
        .wr_ready(f_ready), .rd_valid(b_valid), .rd_data(b_cmd), .rd_ready(b_ready)
    );

    sm3_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .digest_done(digest_done)
    );

endmodule
`default_nettype wire

/* sv/sm3_front.sv */
`default_nettype none
// Pack bytes into block words, pad and append length on the last item
module sm3_front
    import sm3_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    output logic full,
    input wire logic [31:0] message_word,
    input wire logic [2:0] byte_count,
    input wire logic last_word,
    output logic cmd_valid,
    output cmd_t cmd,
    input wire logic cmd_ready
);

    fr_state_t state_reg, state_next;
    logic [23:0] part_reg, part_next;     // bytes of the open word
    logic [1:0] pcnt_reg, pcnt_next;      // bytes in part_reg
    logic [3:0] widx_reg, widx_next;      // words sent in this block
    logic [63:0] len_reg, len_next;       // bits absorbed
    logic in_msg_reg, in_msg_next;
    logic first_reg, first_next;          // next block is first of message
    logic len_hi_reg, len_hi_next;        // length words go into this block
    logic [2:0] n;
    logic [55:0] acc;
    logic [2:0] tot;
    logic accept;

    // Saturate byte count
    assign n = (byte_count > 3'd4) ? 3'd4 : byte_count;

    always_comb
    begin
        state_next = state_reg;
        part_next = part_reg;
        pcnt_next = pcnt_reg;
        widx_next = widx_reg;
        len_next = len_reg;
        in_msg_next = in_msg_reg;
        first_next = first_reg;
        len_hi_next = len_hi_reg;
        full = 1'b1;
        cmd_valid = 1'b0;
        cmd.op = OP_WORD;
        cmd.first = first_reg;
        cmd.data = 32'd0;
        accept = 1'b0;
        acc = 56'd0;
        tot = 3'd0;
        case (state_reg)
            FR_IDLE:
            begin
                // Append new bytes to partial word
                acc = {32'd0, part_reg} << {n, 3'b000};
                acc = acc | ({24'd0, message_word} & ~(56'hFFFFFFFFFFFFFF << {n, 3'b000}));
                tot = {1'b0, pcnt_reg} + n;
                cmd.data = acc[{tot - 3'd4, 3'b000} +: 32];
                cmd.first = first_reg | ~in_msg_reg;
                full = (tot >= 3'd4) && !cmd_ready;
                accept = push && !full;
                if (accept)
                begin
                    len_next = (in_msg_reg ? len_reg : 64'd0) + {58'd0, n, 3'b000};
                    if (!in_msg_reg)
                    begin
                        first_next = 1'b1;
                        widx_next = 4'd0;
                    end
                    in_msg_next = 1'b1;
                    if (tot >= 3'd4)
                    begin
                        cmd_valid = 1'b1;
                        first_next = 1'b0;
                        widx_next = (in_msg_reg ? widx_reg : 4'd0) + 4'd1;
                        pcnt_next = tot[1:0];
                        part_next = acc[23:0];
                    end
                    else
                    begin
                        pcnt_next = tot[1:0];
                        part_next = acc[23:0];
                    end
                    if (!in_msg_reg && tot < 3'd4)
                        pcnt_next = tot[1:0];
                    if (last_word)
                        state_next = FR_PAD;
                end
            end
            FR_PAD:
            begin
                // Close the open word with 0x80 and zeros
                cmd_valid = 1'b1;
                case (pcnt_reg)
                    2'd0: cmd.data = {PAD_BYTE, 24'd0};
                    2'd1: cmd.data = {part_reg[7:0], PAD_BYTE, 16'd0};
                    2'd2: cmd.data = {part_reg[15:0], PAD_BYTE, 8'd0};
                    default: cmd.data = {part_reg, PAD_BYTE};
                endcase
                if (cmd_ready)
                begin
                    pcnt_next = 2'd0;
                    first_next = 1'b0;
                    widx_next = widx_reg + 4'd1;
                    // Pad in word 14 leaves no room for the length: use one more block
                    len_hi_next = (widx_reg != 4'd14);
                    state_next = FR_LEN;
                end
            end
            FR_LEN:
            begin
                // Zero words until position 14, then the two length words
                cmd_valid = 1'b1;
                if (len_hi_reg && widx_reg == 4'd14)
                    cmd.data = len_reg[63:32];
                else if (len_hi_reg && widx_reg == 4'd15)
                    cmd.data = len_reg[31:0];
                else
                    cmd.data = 32'd0;
                if (cmd_ready)
                begin
                    first_next = 1'b0;
                    widx_next = widx_reg + 4'd1;
                    if (widx_reg == 4'd15)
                    begin
                        if (len_hi_reg)
                            state_next = FR_FIN;
                        else
                            len_hi_next = 1'b1;
                    end
                end
            end
            FR_FIN:
            begin
                cmd_valid = 1'b1;
                cmd.op = OP_FINAL;
                if (cmd_ready)
                begin
                    in_msg_next = 1'b0;
                    widx_next = 4'd0;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            pcnt_reg <= 2'd0;
            widx_reg <= 4'd0;
            in_msg_reg <= 1'b0;
            first_reg <= 1'b1;
            len_hi_reg <= 1'b0;
            len_reg <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg <= pcnt_next;
            widx_reg <= widx_next;
            in_msg_reg <= in_msg_next;
            first_reg <= first_next;
            len_hi_reg <= len_hi_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

endmodule
`default_nettype wire

/* sv/sm3_queue.sv */
`default_nettype none
// Four-entry command queue between front and back
module sm3_queue
    import sm3_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic wr_valid,
    input wire cmd_t wr_data,
    output logic wr_ready,
    output logic rd_valid,
    output cmd_t rd_data,
    input wire logic rd_ready
);

    cmd_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en)
                rp_reg <= rp_reg + 2'd1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 3'd1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 3'd1;
        end
    end

endmodule
`default_nettype wire

/* sv/sm3_back.sv */
`default_nettype none
// Collect 16 words, run 64 rounds, emit digest words
module sm3_back
    import sm3_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire cmd_t cmd,
    output logic cmd_ready,
    output logic empty,
    input wire logic pop,
    output logic [31:0] digest_word,
    output logic [2:0] word_index,
    output logic digest_done
);

    bk_state_t state_reg, state_next;
    logic [31:0] w_reg [16];       // sliding window of W[j..j+15]
    logic [31:0] v_reg [8];
    logic [31:0] cv_reg [8];
    logic [3:0] lcnt_reg;
    logic [5:0] rnd_reg;
    logic [2:0] oidx_reg;
    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    logic [31:0] cv_src [8];
    logic [31:0] iv [8];
    logic load_en, round_en, fin_en, pop_en;

    assign iv[0] = IV_A; assign iv[1] = IV_B; assign iv[2] = IV_C; assign iv[3] = IV_D;
    assign iv[4] = IV_E; assign iv[5] = IV_F; assign iv[6] = IV_G; assign iv[7] = IV_H;

    // Chaining value used for a block: IV at message start
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            cv_src[i] = cmd.first ? iv[i] : cv_reg[i];
    end

    // One compression round
    always_comb
    begin
        t = (rnd_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(v_reg[0], 5'd12);
        ss1 = rotl(a12 + v_reg[4] + rotl(t, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + w_reg[0];
        wnew = p1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15)) ^
               rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready = 1'b0;
        load_en = 1'b0;
        round_en = 1'b0;
        fin_en = 1'b0;
        empty = 1'b1;
        case (state_reg)
            BK_LOAD:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && cmd.op == OP_FINAL)
                begin
                    fin_en = 1'b1;
                    state_next = BK_EMIT;
                end
                else if (cmd_valid)
                begin
                    load_en = 1'b1;
                    if (lcnt_reg == 4'd15)
                        state_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                round_en = 1'b1;
                if (rnd_reg == 6'd63)
                    state_next = BK_LOAD;
            end
            BK_EMIT:
            begin
                empty = 1'b0;
                if (pop && oidx_reg == 3'd7)
                    state_next = BK_LOAD;
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    assign pop_en = pop && !empty;
    assign digest_word = cv_reg[oidx_reg];
    assign word_index = oidx_reg;
    assign digest_done = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
            lcnt_reg <= 4'd0;
            rnd_reg <= 6'd0;
            oidx_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_en)
                lcnt_reg <= lcnt_reg + 4'd1;
            if (round_en)
                rnd_reg <= rnd_reg + 6'd1;
            if (pop_en)
                oidx_reg <= oidx_reg + 3'd1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= cmd.data;
            if (lcnt_reg == 4'd0)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= cv_src[i];
                    cv_reg[i] <= cv_src[i];
                end
            end
        end
        if (round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= rotl(v_reg[1], 5'd9);
            v_reg[1] <= v_reg[0];
            v_reg[0] <= tt1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= rotl(v_reg[5], 5'd19);
            v_reg[5] <= v_reg[4];
            v_reg[4] <= p0(tt2);
            if (rnd_reg == 6'd63)
            begin
                cv_reg[0] <= cv_reg[0] ^ tt1;
                cv_reg[1] <= cv_reg[1] ^ v_reg[0];
                cv_reg[2] <= cv_reg[2] ^ rotl(v_reg[1], 5'd9);
                cv_reg[3] <= cv_reg[3] ^ v_reg[2];
                cv_reg[4] <= cv_reg[4] ^ p0(tt2);
                cv_reg[5] <= cv_reg[5] ^ v_reg[4];
                cv_reg[6] <= cv_reg[6] ^ rotl(v_reg[5], 5'd19);
                cv_reg[7] <= cv_reg[7] ^ v_reg[6];
            end
        end
        // A final with no prior block of this message cannot occur
        if (fin_en && cmd.first)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= iv[i];
        end
    end

endmodule
`default_nettype wire

/* bench/sm3_hash_engine_top_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module sm3_hash_engine_top_test;
    import sm3_pkg::*;

    typedef struct {
        logic [31:0] data;
        logic [2:0] nbytes;
        logic last;
    } msg_item_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0] index;
        logic done;
    } digest_item_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [31:0] message_word;
    logic [2:0] byte_count;
    logic last_word;
    logic empty;
    logic pop;
    logic [31:0] digest_word;
    logic [2:0] word_index;
    logic digest_done;

    sm3_hash_engine_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .message_word(message_word),
        .byte_count(byte_count),
        .last_word(last_word),
        .empty(empty),
        .pop(pop),
        .digest_word(digest_word),
        .word_index(word_index),
        .digest_done(digest_done)
    );

    msg_item_t pending_words[$];
    digest_item_t expected_digests[$];

    // Predictor state
    logic [31:0] chain[8];
    logic [7:0] block_bytes[64];
    int unsigned fill_count;
    logic [63:0] bits_done;
    bit msg_open;

    int mismatch_count;
    int digests_seen;
    int messages_sent;
    int words_sent;
    bit no_idle;
    bit hold_sender;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        n = n % 32;
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    // Run one SM3 compression of the gathered block into the chaining value
    task automatic compress_gathered();
        logic [31:0] w[68];
        logic [31:0] v[8];
        logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, x;
        for (int j = 0; j < 16; j++)
            w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
                    block_bytes[4*j+3]};
        for (int j = 16; j < 68; j++)
        begin
            x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
            w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
        end
        for (int j = 0; j < 8; j++)
            v[j] = chain[j];
        for (int j = 0; j < 64; j++)
        begin
            t = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol(v[0], 12);
            ss1 = rol(a12 + v[4] + rol(t, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end
            else
            begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + v[7] + ss1 + w[j];
            v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
            v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
            v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        for (int j = 0; j < 8; j++)
            chain[j] ^= v[j];
    endtask

    task automatic gather_byte(input logic [7:0] b);
        block_bytes[fill_count] = b;
        fill_count++;
        if (fill_count == 64)
        begin
            compress_gathered();
            bits_done += 64'd512;
            fill_count = 0;
        end
    endtask

    // Absorb one accepted word, queue the digest on the last one
    task automatic predict_digest(input msg_item_t it);
        int n;
        logic [63:0] total;
        digest_item_t d;
        n = (it.nbytes > 3'd4) ? 4 : int'(it.nbytes);
        if (!msg_open)
        begin
            chain = '{IV_A, IV_B, IV_C, IV_D, IV_E, IV_F, IV_G, IV_H};
            fill_count = 0;
            bits_done = '0;
            msg_open = 1'b1;
        end
        for (int i = 0; i < n; i++)
            gather_byte(it.data[(n-1-i)*8 +: 8]);
        if (it.last)
        begin
            total = bits_done + 64'(fill_count * 8);
            gather_byte(PAD_BYTE);
            while (fill_count != 56)
                gather_byte(8'h00);
            for (int i = 0; i < 8; i++)
                gather_byte(total[(7-i)*8 +: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.word = chain[i];
                d.index = 3'(i);
                d.done = (i == 7);
                expected_digests.push_back(d);
            end
            msg_open = 1'b0;
        end
    endtask

    task automatic add_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
        msg_item_t it;
        it.data = data;
        it.nbytes = nb;
        it.last = last;
        pending_words.push_back(it);
    endtask

    // Queue a well-formed message of the given byte length
    task automatic add_message(input int len);
        int left;
        int n;
        left = len;
        do
        begin
            n = (left < 4) ? left : $urandom_range(4, 0);
            if (n > left)
                n = left;
            if (n == 4 && $urandom_range(9, 0) == 0)
                add_word($urandom, 3'($urandom_range(7, 5)), (left == 4));
            else
                add_word($urandom, 3'(n), (left == n));
            left -= n;
        end
        while (left > 0);
        messages_sent++;
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            message_word <= '0;
            byte_count <= '0;
            last_word <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_digest('{message_word, byte_count, last_word});
                words_sent++;
                void'(pending_words.pop_front());
            end
            if (!(push && full))
            begin
                if (pending_words.size() != 0 && !hold_sender &&
                    (no_idle || $urandom_range(99, 0) >= 21)
                    && !(push && !full && pending_words.size() == 0))
                begin
                    push <= 1'b1;
                    message_word <= pending_words[0].data;
                    byte_count <= pending_words[0].nbytes;
                    last_word <= pending_words[0].last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                digests_seen++;
                if (expected_digests.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected digest item %h idx %0d", digest_word, word_index);
                end
                else
                begin
                    if (digest_word !== expected_digests[0].word ||
                        word_index !== expected_digests[0].index ||
                        digest_done !== expected_digests[0].done)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                expected_digests[0].word, expected_digests[0].index,
                                expected_digests[0].done, digest_word, word_index,
                                digest_done);
                    end
                    void'(expected_digests.pop_front());
                end
            end
            pop <= no_idle || ($urandom_range(99, 0) >= 21);
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        mismatch_count = 0;
        digests_seen = 0;
        messages_sent = 0;
        words_sent = 0;
        no_idle = 1'b0;
        hold_sender = 1'b0;
        msg_open = 1'b0;
        fill_count = 0;
        bits_done = '0;
        for (int i = 0; i < 64; i++)
            block_bytes[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, extremes, empty words, block edges
        add_word(32'h0, 3'd0, 1'b1);
        add_word(32'h00616263, 3'd3, 1'b1);
        add_word(32'hffffffff, 3'd4, 1'b0);
        add_word(32'h12345678, 3'd0, 1'b0);
        add_word(32'hdeadbeef, 3'd7, 1'b0);
        add_word(32'h00000000, 3'd5, 1'b0);
        add_word(32'hcafef00d, 3'd6, 1'b0);
        add_word(32'h000000a5, 3'd1, 1'b0);
        add_word(32'h00005a3c, 3'd2, 1'b1);
        add_message(55);
        add_message(56);
        add_message(64);
        messages_sent += 3;

        // Wait until every digest has drained, then hold the sender idle
        wait (pending_words.size() == 0 && !push);
        wait (expected_digests.size() == 0);
        hold_sender = 1'b1;
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        // Random messages, mostly short, a few spanning several blocks
        while (words_sent + pending_words.size() < 380)
        begin
            if (pending_words.size() > 40)
                @(posedge clk);
            else if ($urandom_range(9, 0) == 0)
                add_message($urandom_range(200, 60));
            else
                add_message($urandom_range(70, 0));
            if (words_sent > 150 && words_sent < 230)
                no_idle = 1'b1;
            else
                no_idle = 1'b0;
        end
        no_idle = 1'b0;
        wait (pending_words.size() == 0 && !push);
        wait (expected_digests.size() == 0);
        repeat (200) @(posedge clk);

        $display("Covered %0d messages in %0d words, %0d digest items checked.",
            messages_sent, words_sent, digests_seen);
        if (mismatch_count == 0 && expected_digests.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
